### hw/rtl/iarr_pkg.sv
// ----------------------------------------------------------------------------
// iarr_pkg
// Shared constants, codes and types of the ordered word array with insert,
// remove and search.
// ----------------------------------------------------------------------------
package iarr_pkg;

  // sizes
  localparam int unsigned CAPACITY  = 128;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 3;
  // slots a position can address, and the usable bound that follows
  localparam int unsigned SLOT_CNT  = 1 << POS_W;
  localparam int unsigned LIMIT_MAX = (CAPACITY < SLOT_CNT) ? CAPACITY : SLOT_CNT;
  localparam int unsigned NUM_CELLS = SLOT_CNT;
  localparam int unsigned GRP_SIZE  = 8;
  localparam int unsigned GRP_SEL_W = $clog2(GRP_SIZE);
  localparam int unsigned NUM_GRPS  = NUM_CELLS / GRP_SIZE;
  localparam int unsigned GRP_W     = $clog2(NUM_GRPS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [ST_W-1:0]   st_t;

  // operation codes
  localparam op_t OP_APPEND   = 3'd0;
  localparam op_t OP_REM_LAST = 3'd1;
  localparam op_t OP_REM_AT   = 3'd2;
  localparam op_t OP_INS_AT   = 3'd3;
  localparam op_t OP_SEARCH   = 3'd4;
  localparam op_t OP_READ     = 3'd5;
  localparam op_t OP_WRITE    = 3'd6;

  // status codes
  localparam st_t ST_OK       = 3'd0;
  localparam st_t ST_FULL     = 3'd1;
  localparam st_t ST_EMPTY    = 3'd2;
  localparam st_t ST_BADPOS   = 3'd3;
  localparam st_t ST_NOTFOUND = 3'd4;

  // capacity register reset value
  localparam cnt_t CAP_RESET = cnt_t'(SLOT_CNT);

  // command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SHR,
    CMD_SHL
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      cmp_en;
    pos_t      pos;
    word_t     value;
    cnt_t      count;
  } cell_ctl_t;

endpackage

### hw/rtl/iarr_if.sv
// ----------------------------------------------------------------------------
// iarr_req_if / iarr_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface iarr_req_if;
  logic                 valid;
  logic                 ready;
  iarr_pkg::op_t        op;
  iarr_pkg::pos_t       position;
  iarr_pkg::word_t      value;
  logic                 from_front;

  modport source (output valid, output op, output position, output value,
                  output from_front, input ready);
  modport sink   (input valid, input op, input position, input value,
                  input from_front, output ready);
endinterface

interface iarr_rsp_if;
  logic                 valid;
  logic                 ready;
  iarr_pkg::st_t        status;
  iarr_pkg::pos_t       found_index;
  iarr_pkg::word_t      read_value;
  iarr_pkg::cnt_t       element_count;

  modport source (output valid, output status, output found_index,
                  output read_value, output element_count, input ready);
  modport sink   (input valid, input status, input found_index,
                  input read_value, input element_count, output ready);
endinterface

### hw/rtl/iarr_cell.sv
// ----------------------------------------------------------------------------
// iarr_cell
// One slot of the array: holds a word, shifts to or from its neighbours,
// loads a new word and compares against the search key.
// ----------------------------------------------------------------------------
module iarr_cell (
  input  logic                clk_i,
  input  iarr_pkg::pos_t      idx_i,
  input  iarr_pkg::cell_ctl_t ctl_i,
  input  iarr_pkg::word_t     left_i,
  input  iarr_pkg::word_t     right_i,
  output iarr_pkg::word_t     data_o,
  output logic                hit_o
);
  import iarr_pkg::*;

  word_t data_q, data_d;
  logic  hit_q, hit_d;

  // next word for this slot
  always_comb begin
    data_d = data_q;
    case (ctl_i.cmd)
      CMD_LOAD: begin
        if (idx_i == ctl_i.pos) data_d = ctl_i.value;
      end
      CMD_SHR: begin
        if (idx_i == ctl_i.pos) begin
          data_d = ctl_i.value;
        end else if (idx_i > ctl_i.pos) begin
          data_d = left_i;
        end
      end
      CMD_SHL: begin
        if (idx_i >= ctl_i.pos) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  // key match, only for slots holding an element
  assign hit_d = (data_q == ctl_i.value) && ({1'b0, idx_i} < ctl_i.count);

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctl_i.cmp_en) hit_q <= hit_d;
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

### hw/rtl/iarr_group.sv
// ----------------------------------------------------------------------------
// iarr_group
// Registered reduction over a group of cells: first and last match inside
// the group and the word at the selected offset.
// ----------------------------------------------------------------------------
module iarr_group (
  input  logic                                            clk_i,
  input  logic [iarr_pkg::GRP_SIZE-1:0]                   hit_i,
  input  logic [iarr_pkg::GRP_SIZE-1:0][iarr_pkg::WORD_W-1:0] data_i,
  input  logic [iarr_pkg::GRP_SEL_W-1:0]                  sel_i,
  output logic                                            any_o,
  output logic [iarr_pkg::GRP_SEL_W-1:0]                  first_o,
  output logic [iarr_pkg::GRP_SEL_W-1:0]                  last_o,
  output iarr_pkg::word_t                                 rd_o
);
  import iarr_pkg::*;

  logic                 any_q;
  logic [GRP_SEL_W-1:0] first_q, first_d;
  logic [GRP_SEL_W-1:0] last_q, last_d;
  word_t                rd_q;

  // lowest and highest matching offset
  always_comb begin
    first_d = '0;
    last_d  = '0;
    for (int k = GRP_SIZE - 1; k >= 0; k--) begin
      if (hit_i[k]) first_d = GRP_SEL_W'(k);
    end
    for (int k = 0; k < GRP_SIZE; k++) begin
      if (hit_i[k]) last_d = GRP_SEL_W'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    any_q   <= |hit_i;
    first_q <= first_d;
    last_q  <= last_d;
    rd_q    <= data_i[sel_i];
  end

  assign any_o   = any_q;
  assign first_o = first_q;
  assign last_o  = last_q;
  assign rd_o    = rd_q;

endmodule

### hw/rtl/indexed_array_insert_remove_search_core.sv
// ----------------------------------------------------------------------------
// indexed_array_insert_remove_search_core
// Ordered array of 64-bit words held in a row of cells. Append, remove,
// insert with shift, search from either end, read and write.
// Sequence: a request beat is taken only in the idle state; the cells then shift
//   or compare all slots together, a registered group reduction and a final
//   combine into the response register follow, and that register waits while
//   the previous response beat is still held. Then the block is idle again.
// Reset: element count zero, capacity register 128; cell contents undefined.
// ----------------------------------------------------------------------------
module indexed_array_insert_remove_search_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  iarr_pkg::cnt_t      cfg_wdata_i,
  iarr_req_if.sink            req_i,
  iarr_rsp_if.source          rsp_o
);
  import iarr_pkg::*;

  // control sequence
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_REDUCE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state_q, state_d;

  // request and bookkeeping registers
  op_t   op_q;
  pos_t  pos_q;
  word_t val_q;
  logic  front_q;
  st_t   status_q, status_d;
  cnt_t  count_q, count_d;
  cnt_t  cap_q;

  // response register
  logic  out_valid_q;
  st_t   out_status_q;
  pos_t  out_found_q;
  word_t out_rd_q;
  cnt_t  out_count_q;

  cell_ctl_t ctl;
  cnt_t      limit;
  logic      full;
  logic      req_fire, out_load;

  logic [NUM_CELLS-1:0][WORD_W-1:0] cell_data;
  logic [NUM_CELLS-1:0]             cell_hit;

  logic [NUM_GRPS-1:0]                 grp_any;
  logic [NUM_GRPS-1:0][GRP_SEL_W-1:0]  grp_first;
  logic [NUM_GRPS-1:0][GRP_SEL_W-1:0]  grp_last;
  logic [NUM_GRPS-1:0][WORD_W-1:0]     grp_rd;

  logic  srch_any;
  pos_t  srch_idx;
  st_t   fin_status;
  pos_t  fin_found;
  word_t fin_rd;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // usable limit and full flag
  assign limit = (cap_q > cnt_t'(LIMIT_MAX)) ? cnt_t'(LIMIT_MAX) : cap_q;
  assign full  = (count_q >= limit);

  // decode the request into a cell command, status and new count
  always_comb begin
    ctl.cmd    = CMD_HOLD;
    ctl.cmp_en = (state_q == S_EXEC);
    ctl.pos    = pos_q;
    ctl.value  = val_q;
    ctl.count  = count_q;
    status_d   = status_q;
    count_d    = count_q;
    if (state_q == S_EXEC) begin
      status_d = ST_OK;
      unique case (op_q)
        OP_APPEND: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl.cmd = CMD_LOAD;
            ctl.pos = count_q[POS_W-1:0];
            count_d = count_q + 1'b1;
          end
        end
        OP_REM_LAST: begin
          if (count_q == '0) status_d = ST_EMPTY;
          else count_d = count_q - 1'b1;
        end
        OP_REM_AT: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else if ({1'b0, pos_q} >= count_q) begin
            status_d = ST_BADPOS;
          end else begin
            ctl.cmd = CMD_SHL;
            count_d = count_q - 1'b1;
          end
        end
        OP_INS_AT: begin
          if (full) begin
            status_d = ST_FULL;
          end else if ({1'b0, pos_q} > count_q) begin
            status_d = ST_BADPOS;
          end else begin
            ctl.cmd = CMD_SHR;
            count_d = count_q + 1'b1;
          end
        end
        OP_SEARCH: status_d = ST_NOTFOUND;
        OP_READ: begin
          if ({1'b0, pos_q} >= count_q) status_d = ST_BADPOS;
        end
        OP_WRITE: begin
          if ({1'b0, pos_q} >= count_q) status_d = ST_BADPOS;
          else ctl.cmd = CMD_LOAD;
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  // row of cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == NUM_CELLS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    iarr_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (pos_t'(i)),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .hit_o   (cell_hit[i])
    );
  end

  // group reduction
  for (genvar g = 0; g < NUM_GRPS; g++) begin : g_grp
    iarr_group u_group (
      .clk_i   (clk_i),
      .hit_i   (cell_hit[g*GRP_SIZE +: GRP_SIZE]),
      .data_i  (cell_data[g*GRP_SIZE +: GRP_SIZE]),
      .sel_i   (pos_q[GRP_SEL_W-1:0]),
      .any_o   (grp_any[g]),
      .first_o (grp_first[g]),
      .last_o  (grp_last[g]),
      .rd_o    (grp_rd[g])
    );
  end

  // pick the first or last matching group
  always_comb begin
    srch_idx = '0;
    if (front_q) begin
      for (int g = NUM_GRPS - 1; g >= 0; g--) begin
        if (grp_any[g]) srch_idx = {GRP_W'(g), grp_first[g]};
      end
    end else begin
      for (int g = 0; g < NUM_GRPS; g++) begin
        if (grp_any[g]) srch_idx = {GRP_W'(g), grp_last[g]};
      end
    end
  end

  assign srch_any = |grp_any;

  // final response fields
  always_comb begin
    fin_status = status_q;
    fin_found  = '0;
    fin_rd     = '0;
    if (op_q == OP_SEARCH) begin
      fin_status = srch_any ? ST_OK : ST_NOTFOUND;
      fin_found  = srch_any ? srch_idx : '0;
    end
    if ((op_q == OP_READ) && (status_q == ST_OK)) begin
      fin_rd = grp_rd[pos_q[POS_W-1:GRP_SEL_W]];
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (req_fire) state_d = S_EXEC;
      S_EXEC:   state_d = S_REDUCE;
      S_REDUCE: state_d = S_DONE;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q    <= req_i.op;
      pos_q   <= req_i.position;
      val_q   <= req_i.value;
      front_q <= req_i.from_front;
    end
    status_q <= status_d;
    if (out_load) begin
      out_status_q <= fin_status;
      out_found_q  <= fin_found;
      out_rd_q     <= fin_rd;
      out_count_q  <= count_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.found_index   = out_found_q;
  assign rsp_o.read_value    = out_rd_q;
  assign rsp_o.element_count = out_count_q;

endmodule

### tb/indexed_array_insert_remove_search_core_tb.sv
// ----------------------------------------------------------------------------
// indexed_array_insert_remove_search_core_tb
// Self-checking bench for the ordered word array. A short table of directed
// beats covers the empty and full corners, the bad positions, both search
// directions and a lowered capacity. Phases of random beats then follow under
// several capacity settings. Every request beat runs through a local model of
// the array, and each response beat is compared field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module indexed_array_insert_remove_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iarr_pkg::*;

  // opcode seven carries no operation
  localparam op_t         OP_IGNORED      = 3'd7;
  localparam int unsigned POS_SLOTS       = 128;
  localparam int unsigned RSP_LATENCY     = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT     = 20000;

  typedef struct packed {
    op_t   op;
    pos_t  position;
    word_t value;
    logic  from_front;
  } array_req_t;

  typedef struct packed {
    st_t   status;
    pos_t  found_index;
    word_t read_value;
    cnt_t  element_count;
  } array_rsp_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    array_req_t rq;
    bit         typed;
    array_rsp_t rsp;
    cnt_t       cap;
  } dir_row_t;

  typedef struct {
    bit         typed;
    array_rsp_t rsp;
  } beat_note_t;

  typedef struct {
    cnt_t        cap;
    bit          rand_cap;
    int unsigned items;
    int unsigned grow_pct;
    int unsigned tx_idle;
    int unsigned rx_idle;
    bit          hold;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  cnt_t cfg_wdata_i;

  iarr_req_if req_if ();
  iarr_rsp_if rsp_if ();

  // local copy of the array state
  word_t       array_mirror [POS_SLOTS];
  int unsigned fill_mirror = 0;
  cnt_t        cap_mirror  = CAP_RESET;

  array_rsp_t  expected_rsp_q [$];
  beat_note_t  note_q [$];
  int unsigned fault_count  = 0;
  int unsigned tx_idle_pct  = 20;
  int unsigned rx_idle_pct  = 48;
  bit          hold_off_req = 1'b0;

  word_t value_pool [4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                            64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE};

  phase_t plan [7] = '{
    '{8'd128, 1'b0, 450, 85, 20, 48, 1'b0},
    '{8'd255, 1'b0, 200, 70, 20, 48, 1'b0},
    '{8'd12,  1'b0, 200, 10, 48, 20, 1'b0},
    '{8'd1,   1'b0, 150, 10, 48, 20, 1'b0},
    '{8'd0,   1'b0, 60,  50, 48, 20, 1'b0},
    '{8'd20,  1'b0, 300, 70, 0,  0,  1'b1},
    '{8'd64,  1'b1, 270, 60, 0,  0,  1'b0}
  };

  indexed_array_insert_remove_search_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // array model: applies one request and returns its response
  function automatic array_rsp_t apply_array_op(input array_req_t rq);
    array_rsp_t  rs;
    int unsigned n;
    int unsigned lim;
    int unsigned p;
    rs  = '0;
    rs.status = ST_OK;
    n   = fill_mirror;
    p   = rq.position;
    lim = cap_mirror;
    if (lim > CAPACITY) lim = CAPACITY;
    if (lim > POS_SLOTS) lim = POS_SLOTS;
    case (rq.op)
      OP_APPEND: begin
        if (n >= lim) rs.status = ST_FULL;
        else begin
          array_mirror[n] = rq.value;
          n++;
        end
      end
      OP_REM_LAST: begin
        if (n == 0) rs.status = ST_EMPTY;
        else n--;
      end
      OP_REM_AT: begin
        if (n == 0) rs.status = ST_EMPTY;
        else if (p >= n) rs.status = ST_BADPOS;
        else begin
          for (int unsigned i = p; i + 1 < n; i++) array_mirror[i] = array_mirror[i+1];
          n--;
        end
      end
      OP_INS_AT: begin
        if (n >= lim) rs.status = ST_FULL;
        else if (p > n) rs.status = ST_BADPOS;
        else begin
          for (int unsigned i = n; i > p; i--) array_mirror[i] = array_mirror[i-1];
          array_mirror[p] = rq.value;
          n++;
        end
      end
      OP_SEARCH: begin
        rs.status = ST_NOTFOUND;
        if (rq.from_front) begin
          for (int i = 0; i < int'(n); i++) begin
            if (array_mirror[i] == rq.value) begin
              rs.status      = ST_OK;
              rs.found_index = pos_t'(i);
              break;
            end
          end
        end else begin
          for (int i = int'(n) - 1; i >= 0; i--) begin
            if (array_mirror[i] == rq.value) begin
              rs.status      = ST_OK;
              rs.found_index = pos_t'(i);
              break;
            end
          end
        end
      end
      OP_READ: begin
        if (p < n) rs.read_value = array_mirror[p];
        else rs.status = ST_BADPOS;
      end
      OP_WRITE: begin
        if (p < n) array_mirror[p] = rq.value;
        else rs.status = ST_BADPOS;
      end
      default: ;
    endcase
    fill_mirror      = n;
    rs.element_count = cnt_t'(n);
    return rs;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fault_count++;
    end
  endfunction

  // directed table rows
  function automatic dir_row_t cmd_row(input op_t op, input int unsigned pos,
                                       input word_t v, input bit front);
    dir_row_t row;
    row       = '{kind: ROW_REQ, rq: '0, typed: 1'b0, rsp: '0, cap: '0};
    row.rq    = '{op: op, position: pos_t'(pos), value: v, from_front: front};
    return row;
  endfunction

  function automatic dir_row_t known_row(input op_t op, input int unsigned pos,
                                         input word_t v, input bit front, input st_t st,
                                         input int unsigned fidx, input word_t rd,
                                         input int unsigned cnt);
    dir_row_t row;
    row       = cmd_row(op, pos, v, front);
    row.typed = 1'b1;
    row.rsp   = '{status: st, found_index: pos_t'(fidx), read_value: rd,
                  element_count: cnt_t'(cnt)};
    return row;
  endfunction

  function automatic dir_row_t cap_row(input cnt_t cap);
    dir_row_t row;
    row = '{kind: ROW_CFG, rq: '0, typed: 1'b0, rsp: '0, cap: cap};
    return row;
  endfunction

  // offer one request beat and wait until it is taken
  task automatic offer_request(input array_req_t rq, input bit typed,
                               input array_rsp_t typed_rsp);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    note_q.push_back('{typed: typed, rsp: typed_rsp});
    req_if.valid      <= 1'b1;
    req_if.op         <= rq.op;
    req_if.position   <= rq.position;
    req_if.value      <= rq.value;
    req_if.from_front <= rq.from_front;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // capacity write once the block has gone quiet
  task automatic write_capacity(input cnt_t cap);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (RSP_LATENCY) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // prediction on request beats, comparison on response beats
  always @(posedge clk_i) begin : scoreboard
    array_req_t acc;
    array_rsp_t want;
    beat_note_t note;
    if (rst_ni && cfg_we_i) cap_mirror = cfg_wdata_i;
    if (rst_ni && req_if.valid && req_if.ready) begin
      acc  = '{op: req_if.op, position: req_if.position, value: req_if.value,
               from_front: req_if.from_front};
      want = apply_array_op(acc);
      if (note_q.size() != 0) begin
        note = note_q.pop_front();
        if (note.typed) want = note.rsp;
      end
      expected_rsp_q.push_back(want);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        $error("response beat with no request outstanding");
        fault_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("status", 64'(want.status), 64'(rsp_if.status));
        check_field("found_index", 64'(want.found_index), 64'(rsp_if.found_index));
        check_field("read_value", want.read_value, rsp_if.read_value);
        check_field("element_count", 64'(want.element_count), 64'(rsp_if.element_count));
      end
    end
  end

  // response side: random stalls plus one long hold-off
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left     = 0;
    hold_taken    = 1'b0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // run watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    dir_row_t    dir_rows [$];
    array_req_t  rq;
    int unsigned fill;
    int unsigned pick;
    int unsigned guard;
    req_if.valid      = 1'b0;
    req_if.op         = OP_APPEND;
    req_if.position   = '0;
    req_if.value      = '0;
    req_if.from_front = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = CAP_RESET;

    // empty-array corners, then a short fill and the capacity corners
    dir_rows.push_back(known_row(OP_READ, 0, '0, 1'b1, ST_BADPOS, 0, '0, 0));
    dir_rows.push_back(known_row(OP_REM_LAST, 0, '0, 1'b0, ST_EMPTY, 0, '0, 0));
    dir_rows.push_back(known_row(OP_REM_AT, 0, '0, 1'b0, ST_EMPTY, 0, '0, 0));
    dir_rows.push_back(known_row(OP_SEARCH, 0, '0, 1'b1, ST_NOTFOUND, 0, '0, 0));
    dir_rows.push_back(known_row(OP_INS_AT, 1, '0, 1'b0, ST_BADPOS, 0, '0, 0));
    dir_rows.push_back(known_row(OP_INS_AT, 0, value_pool[1], 1'b0, ST_OK, 0, '0, 1));
    dir_rows.push_back(known_row(OP_APPEND, 127, value_pool[0], 1'b1, ST_OK, 0, '0, 2));
    dir_rows.push_back(known_row(OP_APPEND, 0, value_pool[2], 1'b0, ST_OK, 0, '0, 3));
    dir_rows.push_back(known_row(OP_APPEND, 0, value_pool[1], 1'b0, ST_OK, 0, '0, 4));
    dir_rows.push_back(known_row(OP_READ, 0, '0, 1'b0, ST_OK, 0, value_pool[1], 4));
    dir_rows.push_back(known_row(OP_SEARCH, 127, value_pool[1], 1'b1, ST_OK, 0, '0, 4));
    dir_rows.push_back(known_row(OP_SEARCH, 0, value_pool[1], 1'b0, ST_OK, 3, '0, 4));
    dir_rows.push_back(known_row(OP_WRITE, 127, value_pool[1], 1'b0, ST_BADPOS, 0, '0, 4));
    dir_rows.push_back(known_row(OP_REM_AT, 127, '0, 1'b0, ST_BADPOS, 0, '0, 4));
    dir_rows.push_back(known_row(OP_IGNORED, 127, value_pool[1], 1'b1, ST_OK, 0, '0, 4));
    // capacity lowered under the fill level, then zero
    dir_rows.push_back(cap_row(8'd3));
    dir_rows.push_back(known_row(OP_APPEND, 0, value_pool[3], 1'b0, ST_FULL, 0, '0, 4));
    dir_rows.push_back(known_row(OP_INS_AT, 127, value_pool[3], 1'b0, ST_FULL, 0, '0, 4));
    dir_rows.push_back(cap_row(8'd0));
    dir_rows.push_back(known_row(OP_INS_AT, 0, value_pool[3], 1'b0, ST_FULL, 0, '0, 4));
    // capacity above the array size, insert at the end appends
    dir_rows.push_back(cap_row(8'd255));
    dir_rows.push_back(known_row(OP_INS_AT, 4, 64'h0123_4567_89AB_CDEF, 1'b0,
                                 ST_OK, 0, '0, 5));
    dir_rows.push_back(cmd_row(OP_INS_AT, 2, 64'h5555_5555_5555_5555, 1'b0));
    dir_rows.push_back(cmd_row(OP_REM_AT, 0, '0, 1'b0));
    dir_rows.push_back(cmd_row(OP_WRITE, 1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
    dir_rows.push_back(cmd_row(OP_SEARCH, 0, value_pool[0], 1'b0));
    dir_rows.push_back(cmd_row(OP_REM_LAST, 0, '0, 1'b0));
    dir_rows.push_back(cmd_row(OP_READ, 3, '0, 1'b0));

    // reset
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) write_capacity(dir_rows[r].cap);
      else offer_request(dir_rows[r].rq, dir_rows[r].typed, dir_rows[r].rsp);
    end

    // random phases
    foreach (plan[ph]) begin
      if (plan[ph].rand_cap) plan[ph].cap = cnt_t'($urandom_range(2, 127));
      write_capacity(plan[ph].cap);
      tx_idle_pct = plan[ph].tx_idle;
      rx_idle_pct = plan[ph].rx_idle;
      if (plan[ph].hold) hold_off_req = 1'b1;
      for (int unsigned k = 0; k < plan[ph].items; k++) begin
        fill = fill_mirror;
        pick = $urandom_range(99);
        // operation mix, biased to grow or shrink the array
        if (pick < 50) begin
          if ($urandom_range(99) < plan[ph].grow_pct)
            rq.op = $urandom_range(1) ? OP_APPEND : OP_INS_AT;
          else
            rq.op = $urandom_range(1) ? OP_REM_LAST : OP_REM_AT;
        end else if (pick < 66) begin
          rq.op = OP_SEARCH;
        end else if (pick < 80) begin
          rq.op = OP_READ;
        end else if (pick < 97) begin
          rq.op = OP_WRITE;
        end else begin
          rq.op = OP_IGNORED;
        end
        // mostly positions inside or just past the fill level
        if ($urandom_range(99) < 80)
          rq.position = pos_t'($urandom_range(0, (fill > 127) ? 127 : fill));
        else
          rq.position = pos_t'($urandom_range(0, 127));
        // values: repeated words, stored words or fresh random words
        case ($urandom_range(3))
          0: rq.value = value_pool[$urandom_range(3)];
          1: begin
            if (fill != 0) rq.value = array_mirror[$urandom_range(0, fill - 1)];
            else rq.value = {$urandom, $urandom};
          end
          default: rq.value = {$urandom, $urandom};
        endcase
        rq.from_front = $urandom_range(1);
        offer_request(rq, 1'b0, '0);
      end
    end

    // drain and settle
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (expected_rsp_q.size() != 0 && guard < DRAIN_LIMIT) begin
      guard++;
      @(posedge clk_i);
    end
    repeat (4 * RSP_LATENCY) @(posedge clk_i);
    if (expected_rsp_q.size() != 0) begin
      $error("%0d response beats never arrived", expected_rsp_q.size());
      fault_count++;
    end

    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
